// File: design/smts_pkg.sv
`default_nettype none
package smts_pkg;

   localparam int FRAC_BITS = 16;

   localparam int KIND_W = 2;
   localparam int ST_PORT_W = 4;
   localparam int SLOT_W = 3;
   localparam int TGT_W = 4;
   localparam int CHANCE_W = FRAC_BITS + 1;
   localparam int CNTIN_W = 4;
   localparam int RAND_W = FRAC_BITS;
   localparam int SCALE_W = FRAC_BITS + 4;

   localparam int DEF_NUM_STATES = 16;
   localparam int DEF_MAX_EDGES = 8;

   // sized for up to 64 entries per list
   localparam int LIST_LOG = 6;
   localparam int BPROD_W = CHANCE_W + SCALE_W;
   localparam int BTERM_W = BPROD_W - FRAC_BITS;
   localparam int SUM_W = BTERM_W + LIST_LOG;
   localparam int BSUM_W = CHANCE_W + LIST_LOG;
   localparam int NUM_W = SUM_W + 1;
   localparam int DEN_W = BSUM_W + 1;
   localparam int MAG_W = SUM_W;
   localparam int DSR_W = BSUM_W;
   localparam int DVD_W = MAG_W + FRAC_BITS;
   localparam int QMAG_W = FRAC_BITS + 8;
   localparam int SMAG_W = QMAG_W + 1;
   localparam int SCL_W = SMAG_W + 1;
   localparam int NPROD_W = CHANCE_W + SMAG_W;
   localparam int NTERM_W = NPROD_W - FRAC_BITS;
   localparam int SS_W = NTERM_W + LIST_LOG + 2;

   localparam logic [QMAG_W-1:0] Q_LIMIT = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_WR_BAD     = 2'd0,
      KIND_WR_NEUTRAL = 2'd1,
      KIND_SET_COUNTS = 2'd2,
      KIND_SELECT     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [TGT_W-1:0]    target;
      logic [CHANCE_W-1:0] chance;
   } edge_type;

endpackage
`default_nettype wire

// File: design/smts_edge_mem.sv
`default_nettype none
module smts_edge_mem #(
   parameter int DEPTH = smts_pkg::DEF_NUM_STATES * smts_pkg::DEF_MAX_EDGES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire  [ADDR_W-1:0]       wr_addr,
   input  wire smts_pkg::edge_type wr_data,
   input  wire                     rd_en,
   input  wire  [ADDR_W-1:0]       rd_addr,
   output smts_pkg::edge_type      rd_data
);
   import smts_pkg::*;

   edge_type mem [DEPTH];
   edge_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: design/smts_div.sv
`default_nettype none
module smts_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  [smts_pkg::DVD_W-1:0]  dividend,
   input  wire  [smts_pkg::DSR_W-1:0]  divisor,
   output logic                        done,
   output logic [smts_pkg::DVD_W-1:0]  quotient
);
   import smts_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DSR_W-1:0]  rem_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DSR_W-1:0]  dsr_ff;
   logic [DSR_W:0]    rem_sh;
   logic [DSR_W+1:0]  diff;

   // restoring division, one quotient bit per cycle
   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign diff = {1'b0, rem_sh} - {2'b00, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CNT_W'(DVD_W);
            rem_ff <= '0;
            quo_ff <= dividend;
            dsr_ff <= divisor;
         end else if (busy_ff) begin
            if (!diff[DSR_W+1]) begin
               rem_ff <= diff[DSR_W-1:0];
               quo_ff <= {quo_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[DSR_W-1:0];
               quo_ff <= {quo_ff[DVD_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// File: design/scaled_markov_transition_sampler_core.sv
// Markov transition sampler with scaled bad transitions.
// Request channel (req_*): kind 0/1 writes one bad/neutral (target, chance)
// entry, kind 2 sets the list lengths of a state, kind 3 selects the next
// state from req_random_value and req_symptom_scale. Only selects produce a
// response on the rsp_* channel (next state, bad flag, ran-past-end flag).
// Writes are performed when the request is accepted; the block stays idle. A
// select walks the bad list, then the neutral list (each entry: memory read,
// multiply, accumulate), with an end check for each list walked to its end
// without a hit; when both lists are used, setup, the bit-serial divider for
// the neutral rescaling factor (43 quotient bits, one per cycle) and scaling
// come between them. When the bad chances sum to one there is no division.
// A select on an out-of-range state or on empty lists returns that state without a walk.
// One request is processed at a time; req_ready is high while idle.
// The response sits in an output register; the block returns to idle as soon
// as that register is free, so a stalled receiver holds at most one finished
// select while the next request is taken.
// Reset clears list lengths (all lists empty) and the handshake state; entry
// memories are not cleared and must be written before use.
`default_nettype none
module scaled_markov_transition_sampler_core #(
   parameter int NUM_STATES = smts_pkg::DEF_NUM_STATES,
   parameter int MAX_EDGES = smts_pkg::DEF_MAX_EDGES
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [smts_pkg::KIND_W-1:0]       req_kind,
   input  wire  [smts_pkg::ST_PORT_W-1:0]    req_state_index,
   input  wire  [smts_pkg::SLOT_W-1:0]       req_slot,
   input  wire  [smts_pkg::TGT_W-1:0]        req_target,
   input  wire  [smts_pkg::CHANCE_W-1:0]     req_chance,
   input  wire  [smts_pkg::CNTIN_W-1:0]      req_bad_count_in,
   input  wire  [smts_pkg::CNTIN_W-1:0]      req_neutral_count_in,
   input  wire  [smts_pkg::RAND_W-1:0]       req_random_value,
   input  wire  [smts_pkg::SCALE_W-1:0]      req_symptom_scale,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [smts_pkg::TGT_W-1:0]        rsp_next_state,
   output logic                              rsp_went_bad,
   output logic                              rsp_ran_past_end
);
   import smts_pkg::*;

   localparam int ST_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int SI_W = (ST_W > ST_PORT_W) ? ST_W : ST_PORT_W;
   localparam int EG_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int SL_W = (EG_W > SLOT_W) ? EG_W : SLOT_W;
   localparam int DEPTH = NUM_STATES * MAX_EDGES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_EDGES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_BRD, ST_BMUL, ST_BACC, ST_PREDIV, ST_DIV, ST_SCL,
      ST_NRD, ST_NMUL, ST_NACC, ST_EMIT
   } state_type;

   state_type state_ff;

   // request decode
   logic              req_fire;
   logic [SI_W-1:0]   st_wide;
   logic [SL_W-1:0]   slot_wide;
   logic [ST_W-1:0]   st_idx;
   logic [EG_W-1:0]   slot_idx;
   logic              st_ok;
   logic              slot_ok;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] st_base;
   edge_type          wr_entry;
   logic              bad_wr;
   logic              neu_wr;

   // list lengths
   logic [CNT_W-1:0]  bad_cnt_ff [NUM_STATES];
   logic [CNT_W-1:0]  neu_cnt_ff [NUM_STATES];
   logic [CNT_W-1:0]  bc_rd;
   logic [CNT_W-1:0]  nc_rd;
   logic [CNT_W-1:0]  bc_clamp;
   logic [CNT_W-1:0]  nc_clamp;

   // select datapath
   logic [ADDR_W-1:0]  base_ff;
   logic [CNT_W-1:0]   bc_ff;
   logic [CNT_W-1:0]   nc_ff;
   logic [CNT_W-1:0]   i_ff;
   logic [RAND_W-1:0]  r_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [BSUM_W-1:0]  bsum_ff;
   logic [BPROD_W-1:0] bprod_ff;
   logic [NPROD_W-1:0] nprod_ff;
   logic [TGT_W-1:0]   cur_tgt_ff;
   logic [CHANCE_W-1:0] cur_chance_ff;
   logic [TGT_W-1:0]   last_tgt_ff;
   logic               qneg_ff;
   logic [QMAG_W-1:0]  qmag_ff;
   logic               sneg_ff;
   logic [SMAG_W-1:0]  smag_ff;
   logic signed [SS_W-1:0] ssum_ff;
   logic [TGT_W-1:0]   res_tgt_ff;
   logic               res_bad_ff;
   logic               res_past_ff;

   logic               rsp_valid_ff;
   logic [TGT_W-1:0]   rsp_next_state_ff;
   logic               rsp_went_bad_ff;
   logic               rsp_ran_past_end_ff;

   logic [ADDR_W-1:0]  rd_addr;
   logic               bad_rd;
   logic               neu_rd;
   edge_type           bad_data;
   edge_type           neu_data;

   logic [SUM_W-1:0]   bsum_acc_in;
   logic signed [NUM_W-1:0] num;
   logic signed [DEN_W-1:0] den;
   logic [MAG_W-1:0]   num_mag;
   logic [DSR_W-1:0]   den_mag;
   logic               div_start;
   logic               div_done;
   logic [DVD_W-1:0]   div_quot;
   logic signed [SCL_W-1:0] scaling;
   logic [SS_W-1:0]    nterm;
   logic signed [SS_W-1:0] ssum_in;
   logic               out_free;
   logic               emit_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;

   assign st_wide = SI_W'(req_state_index);
   assign slot_wide = SL_W'(req_slot);
   assign st_idx = st_wide[ST_W-1:0];
   assign slot_idx = slot_wide[EG_W-1:0];
   assign st_ok = 32'(req_state_index) < NUM_STATES;
   assign slot_ok = 32'(req_slot) < MAX_EDGES;
   assign st_base = ADDR_W'(32'(st_idx) * MAX_EDGES);
   assign wr_addr = st_base + ADDR_W'(slot_idx);
   assign wr_entry = '{target: req_target, chance: req_chance};
   assign bad_wr = req_fire && st_ok && slot_ok && (req_kind == KIND_WR_BAD);
   assign neu_wr = req_fire && st_ok && slot_ok && (req_kind == KIND_WR_NEUTRAL);

   assign bc_rd = bad_cnt_ff[st_idx];
   assign nc_rd = neu_cnt_ff[st_idx];
   assign bc_clamp = (32'(req_bad_count_in) > MAX_EDGES) ?
                     CNT_W'(MAX_EDGES) : CNT_W'(req_bad_count_in);
   assign nc_clamp = (32'(req_neutral_count_in) > MAX_EDGES) ?
                     CNT_W'(MAX_EDGES) : CNT_W'(req_neutral_count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STATES; k++) begin
            bad_cnt_ff[k] <= '0;
            neu_cnt_ff[k] <= '0;
         end
      end else if (req_fire && st_ok && (req_kind == KIND_SET_COUNTS)) begin
         bad_cnt_ff[st_idx] <= bc_clamp;
         neu_cnt_ff[st_idx] <= nc_clamp;
      end
   end

   assign rd_addr = base_ff + ADDR_W'(i_ff);
   assign bad_rd = (state_ff == ST_BRD) && (i_ff != bc_ff);
   assign neu_rd = (state_ff == ST_NRD) && (i_ff != nc_ff);

   smts_edge_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_bad_mem (
      .clock   (clock),
      .wr_en   (bad_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (bad_rd),
      .rd_addr (rd_addr),
      .rd_data (bad_data)
   );

   smts_edge_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_neu_mem (
      .clock   (clock),
      .wr_en   (neu_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (neu_rd),
      .rd_addr (rd_addr),
      .rd_data (neu_data)
   );

   // rescale numerator/denominator: (badSum - scaledSum) / (1 - badSum)
   assign bsum_acc_in = sum_ff + SUM_W'(bprod_ff[BPROD_W-1:FRAC_BITS]);
   assign num = $signed(NUM_W'(bsum_ff)) - $signed(NUM_W'(sum_ff));
   assign den = $signed(DEN_W'(1 << FRAC_BITS)) - $signed(DEN_W'(bsum_ff));
   assign num_mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
   assign den_mag = den[DEN_W-1] ? DSR_W'(-den) : DSR_W'(den);
   assign div_start = (state_ff == ST_PREDIV) && (den != '0);

   smts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num_mag, {FRAC_BITS{1'b0}}}),
      .divisor  (den_mag),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign scaling = $signed(SCL_W'(1 << FRAC_BITS)) +
                    (qneg_ff ? -$signed(SCL_W'(qmag_ff)) : $signed(SCL_W'(qmag_ff)));
   assign nterm = sneg_ff ? -SS_W'(nprod_ff[NPROD_W-1:FRAC_BITS])
                          : SS_W'(nprod_ff[NPROD_W-1:FRAC_BITS]);
   assign ssum_in = ssum_ff + $signed(nterm);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit_load = (state_ff == ST_EMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_kind == KIND_SELECT)) begin
                  if (!st_ok || (bc_rd == '0 && nc_rd == '0)) begin
                     res_tgt_ff <= req_state_index;
                     res_bad_ff <= 1'b0;
                     res_past_ff <= 1'b0;
                     state_ff <= ST_EMIT;
                  end else begin
                     base_ff <= st_base;
                     bc_ff <= bc_rd;
                     nc_ff <= nc_rd;
                     i_ff <= '0;
                     r_ff <= req_random_value;
                     // no neutral entries: scale taken as one
                     scale_ff <= (nc_rd == '0) ? SCALE_W'(1 << FRAC_BITS)
                                               : req_symptom_scale;
                     sum_ff <= '0;
                     bsum_ff <= '0;
                     state_ff <= ST_BRD;
                  end
               end
            end
            ST_BRD: begin
               if (i_ff == bc_ff) begin
                  i_ff <= '0;
                  if (nc_ff == '0) begin
                     res_tgt_ff <= last_tgt_ff;
                     res_bad_ff <= 1'b1;
                     res_past_ff <= 1'b1;
                     state_ff <= ST_EMIT;
                  end else if (bc_ff == '0) begin
                     smag_ff <= SMAG_W'(1 << FRAC_BITS);
                     sneg_ff <= 1'b0;
                     ssum_ff <= '0;
                     state_ff <= ST_NRD;
                  end else begin
                     state_ff <= ST_PREDIV;
                  end
               end else begin
                  state_ff <= ST_BMUL;
               end
            end
            ST_BMUL: begin
               bprod_ff <= BPROD_W'(bad_data.chance) * BPROD_W'(scale_ff);
               cur_tgt_ff <= bad_data.target;
               cur_chance_ff <= bad_data.chance;
               last_tgt_ff <= bad_data.target;
               state_ff <= ST_BACC;
            end
            ST_BACC: begin
               if (SUM_W'(r_ff) < bsum_acc_in) begin
                  res_tgt_ff <= cur_tgt_ff;
                  res_bad_ff <= 1'b1;
                  res_past_ff <= 1'b0;
                  state_ff <= ST_EMIT;
               end else begin
                  sum_ff <= bsum_acc_in;
                  bsum_ff <= bsum_ff + BSUM_W'(cur_chance_ff);
                  i_ff <= i_ff + CNT_W'(1);
                  state_ff <= ST_BRD;
               end
            end
            ST_PREDIV: begin
               if (den == '0) begin
                  // zero divisor saturates with the numerator's sign
                  qneg_ff <= num[NUM_W-1];
                  qmag_ff <= (num != '0) ? Q_LIMIT : '0;
                  state_ff <= ST_SCL;
               end else begin
                  qneg_ff <= num[NUM_W-1] ^ den[DEN_W-1];
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  qmag_ff <= (div_quot > DVD_W'(Q_LIMIT)) ? Q_LIMIT
                                                         : div_quot[QMAG_W-1:0];
                  state_ff <= ST_SCL;
               end
            end
            ST_SCL: begin
               sneg_ff <= scaling[SCL_W-1];
               smag_ff <= scaling[SCL_W-1] ? SMAG_W'(-scaling) : SMAG_W'(scaling);
               ssum_ff <= $signed(SS_W'(sum_ff));
               state_ff <= ST_NRD;
            end
            ST_NRD: begin
               if (i_ff == nc_ff) begin
                  res_tgt_ff <= last_tgt_ff;
                  res_bad_ff <= 1'b0;
                  res_past_ff <= 1'b1;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_NMUL;
               end
            end
            ST_NMUL: begin
               nprod_ff <= NPROD_W'(neu_data.chance) * NPROD_W'(smag_ff);
               cur_tgt_ff <= neu_data.target;
               last_tgt_ff <= neu_data.target;
               state_ff <= ST_NACC;
            end
            ST_NACC: begin
               if (ssum_in >= $signed(SS_W'(r_ff))) begin
                  res_tgt_ff <= cur_tgt_ff;
                  res_bad_ff <= 1'b0;
                  res_past_ff <= 1'b0;
                  state_ff <= ST_EMIT;
               end else begin
                  ssum_ff <= ssum_in;
                  i_ff <= i_ff + CNT_W'(1);
                  state_ff <= ST_NRD;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_next_state_ff <= res_tgt_ff;
                  rsp_went_bad_ff <= res_bad_ff;
                  rsp_ran_past_end_ff <= res_past_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_next_state = rsp_next_state_ff;
   assign rsp_went_bad = rsp_went_bad_ff;
   assign rsp_ran_past_end = rsp_ran_past_end_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside emit state");

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BACC |-> i_ff < bc_ff)
      else $error("bad list index beyond count");

   a_neu_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NACC |-> i_ff < nc_ff)
      else $error("neutral list index beyond count");

endmodule
`default_nettype wire

// File: dv/tb_scaled_markov_transition_sampler_core.sv
`timescale 1ns / 1ps
module tb_scaled_markov_transition_sampler_core;
   import smts_pkg::*;

   localparam int N_ST = 16;
   localparam int N_EDGE = 8;
   localparam int ONE = 1 << FRAC_BITS;
   localparam longint QLIM = (longint'(1) << (FRAC_BITS + 8)) - 1;
   localparam int N_RANDOM = 800;
   localparam int QUIET_FROM = 700;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 150;

   typedef struct packed {
      logic [TGT_W-1:0] next_state;
      logic             went_bad;
      logic             ran_past_end;
   } pick_type;

   class transition_scoreboard;
      logic [TGT_W-1:0]    bad_tgt[N_ST*N_EDGE];
      logic [CHANCE_W-1:0] bad_ch[N_ST*N_EDGE];
      logic [TGT_W-1:0]    neu_tgt[N_ST*N_EDGE];
      logic [CHANCE_W-1:0] neu_ch[N_ST*N_EDGE];
      int unsigned         bad_len[N_ST];
      int unsigned         neu_len[N_ST];
      pick_type            pending[$];
      int                  errors;

      function new();
         foreach (bad_len[i]) begin
            bad_len[i] = 0;
            neu_len[i] = 0;
         end
         errors = 0;
      endfunction

      function pick_type pick_next(int unsigned st, longint r, longint sc);
         pick_type p;
         int unsigned bc, nc, base;
         longint sum, bsum, num, den, q, scaling, ssum, an, ad, mag, term;
         bit neg;
         bc = bad_len[st];
         nc = neu_len[st];
         base = st * N_EDGE;
         sum = 0;
         bsum = 0;
         p = '{next_state: TGT_W'(st), went_bad: 1'b0, ran_past_end: 1'b0};
         if (bc == 0 && nc == 0) return p;
         if (nc == 0) sc = ONE;
         for (int i = 0; i < bc; i++) begin
            sum += (longint'(bad_ch[base+i]) * sc) >>> FRAC_BITS;
            if (r < sum) begin
               p = '{next_state: bad_tgt[base+i], went_bad: 1'b1, ran_past_end: 1'b0};
               return p;
            end
            bsum += longint'(bad_ch[base+i]);
         end
         if (nc == 0) begin
            p = '{next_state: bad_tgt[base+bc-1], went_bad: 1'b1, ran_past_end: 1'b1};
            return p;
         end
         scaling = ONE;
         if (bc != 0) begin
            num = bsum - sum;
            den = ONE - bsum;
            if (den == 0) begin
               q = (num > 0) ? QLIM : ((num < 0) ? -QLIM : 0);
            end else begin
               neg = (num < 0) != (den < 0);
               an = (num < 0) ? -num : num;
               ad = (den < 0) ? -den : den;
               mag = (an << FRAC_BITS) / ad;
               if (mag > QLIM) mag = QLIM;
               q = neg ? -mag : mag;
            end
            scaling = ONE + q;
         end
         ssum = sum;
         for (int i = 0; i < nc; i++) begin
            neg = scaling < 0;
            mag = neg ? -scaling : scaling;
            term = (longint'(neu_ch[base+i]) * mag) >>> FRAC_BITS;
            ssum += neg ? -term : term;
            if (ssum >= r) begin
               p = '{next_state: neu_tgt[base+i], went_bad: 1'b0, ran_past_end: 1'b0};
               return p;
            end
         end
         p = '{next_state: neu_tgt[base+nc-1], went_bad: 1'b0, ran_past_end: 1'b1};
         return p;
      endfunction

      function void note_request(kind_type k, int unsigned st, int unsigned slot,
                                 logic [TGT_W-1:0] tgt, logic [CHANCE_W-1:0] ch,
                                 int unsigned bcin, int unsigned ncin,
                                 longint r, longint sc);
         int unsigned idx;
         idx = st * N_EDGE + slot;
         case (k)
            KIND_WR_BAD: begin
               bad_tgt[idx] = tgt;
               bad_ch[idx] = ch;
            end
            KIND_WR_NEUTRAL: begin
               neu_tgt[idx] = tgt;
               neu_ch[idx] = ch;
            end
            KIND_SET_COUNTS: begin
               bad_len[st] = (bcin > N_EDGE) ? N_EDGE : bcin;
               neu_len[st] = (ncin > N_EDGE) ? N_EDGE : ncin;
            end
            default: pending.insert(pending.size(), pick_next(st, r, sc));
         endcase
      endfunction

      function void check_response(pick_type got);
         pick_type want;
         if (pending.size() == 0) begin
            $error("unexpected response next_state=%0d", got.next_state);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.next_state !== want.next_state) begin
            $error("next_state expected %0d actual %0d", want.next_state, got.next_state);
            errors++;
         end
         if (got.went_bad !== want.went_bad) begin
            $error("went_bad expected %0d actual %0d", want.went_bad, got.went_bad);
            errors++;
         end
         if (got.ran_past_end !== want.ran_past_end) begin
            $error("ran_past_end expected %0d actual %0d",
                   want.ran_past_end, got.ran_past_end);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind = '0;
   logic [ST_PORT_W-1:0] req_state_index = '0;
   logic [SLOT_W-1:0]    req_slot = '0;
   logic [TGT_W-1:0]     req_target = '0;
   logic [CHANCE_W-1:0]  req_chance = '0;
   logic [CNTIN_W-1:0]   req_bad_count_in = '0;
   logic [CNTIN_W-1:0]   req_neutral_count_in = '0;
   logic [RAND_W-1:0]    req_random_value = '0;
   logic [SCALE_W-1:0]   req_symptom_scale = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [TGT_W-1:0]     rsp_next_state;
   logic                 rsp_went_bad;
   logic                 rsp_ran_past_end;

   transition_scoreboard sb = new();
   bit   quiet = 1'b0;
   int   idle_cycles = 0;
   int   stall_left = 0;
   bit   bad_written[N_ST][N_EDGE];
   bit   neu_written[N_ST][N_EDGE];

   scaled_markov_transition_sampler_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_state_index(req_state_index),
      .req_slot(req_slot), .req_target(req_target), .req_chance(req_chance),
      .req_bad_count_in(req_bad_count_in),
      .req_neutral_count_in(req_neutral_count_in),
      .req_random_value(req_random_value),
      .req_symptom_scale(req_symptom_scale),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_next_state(rsp_next_state), .rsp_went_bad(rsp_went_bad),
      .rsp_ran_past_end(rsp_ran_past_end)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // request and response monitors
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(kind_type'(req_kind), int'(req_state_index), int'(req_slot),
                            req_target, req_chance, int'(req_bad_count_in),
                            int'(req_neutral_count_in), longint'(req_random_value),
                            longint'(req_symptom_scale));
         if (rsp_valid && rsp_ready)
            sb.check_response('{next_state: rsp_next_state, went_bad: rsp_went_bad,
                                ran_past_end: rsp_ran_past_end});
      end
   end

   // random receiver back-pressure in bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_scaled_markov_transition_sampler_core failed");
         $finish;
      end
   end

   task automatic send(kind_type k, int st, int slot, int tgt, int ch,
                       int bcin, int ncin, int r, int sc);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_state_index <= ST_PORT_W'(st);
      req_slot <= SLOT_W'(slot);
      req_target <= TGT_W'(tgt);
      req_chance <= CHANCE_W'(ch);
      req_bad_count_in <= CNTIN_W'(bcin);
      req_neutral_count_in <= CNTIN_W'(ncin);
      req_random_value <= RAND_W'(r);
      req_symptom_scale <= SCALE_W'(sc);
      if (k == KIND_WR_BAD) bad_written[st][slot] = 1'b1;
      if (k == KIND_WR_NEUTRAL) neu_written[st][slot] = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic int rand_chance();
      case ($urandom_range(0, 7))
         0: return ONE;
         1: return $urandom_range(0, 131071);
         2: return $urandom_range(0, 255);
         3, 4: return $urandom_range(0, 65536);
         default: return $urandom_range(0, 20000);
      endcase
   endfunction

   function automatic int rand_scale();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1048575);
         1: return ONE;
         default: return $urandom_range(0, 3 * ONE);
      endcase
   endfunction

   // longest run of written slots from slot 0
   function automatic int written_prefix(bit bad, int st);
      int n;
      n = 0;
      while (n < N_EDGE && (bad ? bad_written[st][n] : neu_written[st][n])) n++;
      return n;
   endfunction

   function automatic int rand_count(int avail);
      if (avail == N_EDGE && $urandom_range(0, 3) == 0) return $urandom_range(8, 15);
      return $urandom_range(0, avail);
   endfunction

   initial begin
      int st, k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty state, zero divisor, negative rescale, one-sided lists
      send(KIND_SELECT, 1, 0, 0, 0, 0, 0, 0, 0);
      send(KIND_WR_BAD, 0, 0, 3, 32768, 0, 0, 0, 0);
      send(KIND_WR_BAD, 0, 1, 4, 32768, 0, 0, 0, 0);
      send(KIND_WR_NEUTRAL, 0, 0, 5, 0, 0, 0, 0, 0);
      send(KIND_WR_NEUTRAL, 0, 1, 15, ONE, 0, 0, 0, 0);
      send(KIND_SET_COUNTS, 0, 0, 0, 0, 2, 2, 0, 0);
      send(KIND_SELECT, 0, 0, 0, 0, 0, 0, 0, 0);
      send(KIND_SELECT, 0, 0, 0, 0, 0, 0, 65535, ONE);
      send(KIND_SELECT, 0, 0, 0, 0, 0, 0, 65535, 20'hFFFFF);
      send(KIND_WR_BAD, 2, 0, 7, 100, 0, 0, 0, 0);
      send(KIND_SET_COUNTS, 2, 0, 0, 0, 1, 0, 0, 0);
      send(KIND_SELECT, 2, 0, 0, 0, 0, 0, 65535, 20'hFFFFF);
      send(KIND_WR_NEUTRAL, 3, 0, 9, 131071, 0, 0, 0, 0);
      send(KIND_WR_NEUTRAL, 3, 7, 2, 100, 0, 0, 0, 0);
      send(KIND_SET_COUNTS, 3, 0, 0, 0, 0, 1, 0, 0);
      send(KIND_SELECT, 3, 0, 0, 0, 0, 0, 65535, 0);
      send(KIND_WR_BAD, 4, 0, 2, 30000, 0, 0, 0, 0);
      send(KIND_WR_NEUTRAL, 4, 0, 6, 20000, 0, 0, 0, 0);
      send(KIND_WR_NEUTRAL, 4, 1, 8, 40000, 0, 0, 0, 0);
      send(KIND_SET_COUNTS, 4, 0, 0, 0, 1, 2, 0, 0);
      send(KIND_SELECT, 4, 0, 0, 0, 0, 0, 65000, 2 * ONE);
      send(KIND_SELECT, 4, 0, 0, 0, 0, 0, 65535, 0);
      send(KIND_SELECT, 15, 0, 0, 0, 0, 0, 0, 0);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == QUIET_FROM) quiet = 1'b1;
         st = $urandom_range(0, N_ST - 1);
         k = $urandom_range(0, 19);
         if (k < 6)
            send(KIND_WR_BAD, st, $urandom_range(0, N_EDGE - 1), $urandom_range(0, 15),
                 rand_chance(), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 65535), $urandom_range(0, 1048575));
         else if (k < 11)
            send(KIND_WR_NEUTRAL, st, $urandom_range(0, N_EDGE - 1), $urandom_range(0, 15),
                 rand_chance(), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 65535), $urandom_range(0, 1048575));
         else if (k < 14)
            send(KIND_SET_COUNTS, st, $urandom_range(0, 7), $urandom_range(0, 15),
                 $urandom_range(0, 131071), rand_count(written_prefix(1, st)),
                 rand_count(written_prefix(0, st)), $urandom_range(0, 65535),
                 $urandom_range(0, 1048575));
         else
            send(KIND_SELECT, st, $urandom_range(0, 7), $urandom_range(0, 15),
                 $urandom_range(0, 131071), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 65535), rand_scale());
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_scaled_markov_transition_sampler_core passed");
      end else begin
         $display("tb_scaled_markov_transition_sampler_core failed");
      end
      $finish;
   end

endmodule
